@@ src/ssi_pkg.sv @@
package ssi_pkg;

   // field and datapath widths
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int PROD_W  = 2 * DIFF_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int MAG_W   = SUM_W;
   localparam int FRAC_W  = 16;
   localparam int NUM_W   = MAG_W + FRAC_W + 2;
   localparam int DEN_W   = MAG_W + 1;
   localparam int QUO_W   = 32;
   localparam int REM_W   = DEN_W + QUO_W + 1;
   localparam int T_W     = 32;

   localparam logic [QUO_W-2:0] T_ONE   = (QUO_W-1)'(1) << FRAC_W;
   localparam logic [T_W-1:0]   T_MAX   = {1'b0, {(T_W-1){1'b1}}};
   localparam logic [T_W-1:0]   T_MIN   = {1'b1, {(T_W-1){1'b0}}};

   // input beat
   typedef struct packed {
      logic signed [COORD_W-1:0] first_start_x;
      logic signed [COORD_W-1:0] first_start_y;
      logic signed [COORD_W-1:0] first_end_x;
      logic signed [COORD_W-1:0] first_end_y;
      logic signed [COORD_W-1:0] second_start_x;
      logic signed [COORD_W-1:0] second_start_y;
      logic signed [COORD_W-1:0] second_end_x;
      logic signed [COORD_W-1:0] second_end_y;
      logic                      infinite_first;
   } req_type;

   // result beat
   typedef struct packed {
      logic                  hit;
      logic signed [T_W-1:0] hit_param;
   } rsp_type;

   // decision flags handed from the geometry stages to the divider
   typedef struct packed {
      logic cand;
      logic check_t;
   } cand_type;

   function automatic logic signed [DIFF_W-1:0] diff16(input logic signed [COORD_W-1:0] a,
                                                        input logic signed [COORD_W-1:0] b);
      return DIFF_W'(a) - DIFF_W'(b);
   endfunction

endpackage

@@ src/ssi_req_if.sv @@
interface ssi_req_if;
   import ssi_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/ssi_rsp_if.sv @@
interface ssi_rsp_if;
   import ssi_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ src/segment_segment_intersection.sv @@
// beats pass the geometry and divider stages; all stages stall while the buffer is full
// throughput: one segment pair per cycle when not stalled; the quotient is built one bit
// per stage over 32 pipelined restoring steps, so the divider sets the depth, not the rate
// a two-entry output buffer lets the pipeline run on while one result waits
// reset (synchronous, active high) clears all valid bits and the output buffer
module segment_segment_intersection (
   input logic        clock,
   input logic        reset,
   ssi_req_if.sink    req_bus,
   ssi_rsp_if.source  rsp_bus
);
   import ssi_pkg::*;

   logic                    en;
   logic                    geom_valid, div_valid;
   logic signed [SUM_W-1:0] geom_n, geom_d;
   cand_type                geom_ctl;
   rsp_type                 div_rsp;

   // whole pipeline advances while the output buffer has room
   assign req_bus.ready = en;

   ssi_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_data   (req_bus.data),
      .out_valid (geom_valid),
      .out_n     (geom_n),
      .out_d     (geom_d),
      .out_ctl   (geom_ctl)
   );

   ssi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (geom_valid),
      .in_n      (geom_n),
      .in_d      (geom_d),
      .in_ctl    (geom_ctl),
      .out_valid (div_valid),
      .out_rsp   (div_rsp)
   );

   ssi_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_data   (div_rsp),
      .room      (en),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (rsp_bus.data)
   );

endmodule

@@ src/ssi_geom.sv @@
module ssi_geom (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  ssi_pkg::req_type                   in_data,
   output logic                               out_valid,
   output logic signed [ssi_pkg::SUM_W-1:0]   out_n,
   output logic signed [ssi_pkg::SUM_W-1:0]   out_d,
   output ssi_pkg::cand_type                  out_ctl
);
   import ssi_pkg::*;

   // stage 1: edge vectors
   logic signed [DIFF_W-1:0] rx_ff, ry_ff, sx_ff, sy_ff, dx_ff, dy_ff, ex_ff, ey_ff;
   logic                     inf1_ff, v1_ff;
   // stage 2: products
   logic signed [PROD_W-1:0] p_rxsy_ff, p_rysx_ff, p_dxsy_ff, p_dysx_ff, p_dxry_ff, p_dyrx_ff;
   logic signed [PROD_W-1:0] p_rxrx_ff, p_ryry_ff, p_dxrx_ff, p_dyry_ff, p_exrx_ff, p_eyry_ff;
   logic                     inf2_ff, v2_ff;
   // stage 3: cross and dot sums
   logic signed [SUM_W-1:0]  rxs_ff, num_t_ff, num_u_ff, rr_ff, n0_ff, n1_ff;
   logic                     inf3_ff, v3_ff;
   // stage 4: case decision
   logic signed [SUM_W-1:0]  n_ff, d_ff, n_in, d_in;
   cand_type                 ctl_ff, ctl_in;
   logic                     v4_ff;

   logic signed [SUM_W-1:0]  nmin, nmax;
   logic                     min_ok, max_ok, u_ok;

   // case selection and exact range tests
   always_comb begin
      nmin   = (n0_ff < n1_ff) ? n0_ff : n1_ff;
      nmax   = (n0_ff < n1_ff) ? n1_ff : n0_ff;
      min_ok = (nmin >= 0) && (nmin <= rr_ff);
      max_ok = (nmax >= 0) && (nmax <= rr_ff);
      if (rxs_ff < 0) begin
         u_ok = (num_u_ff <= 0) && (num_u_ff >= rxs_ff);
      end else begin
         u_ok = (num_u_ff >= 0) && (num_u_ff <= rxs_ff);
      end
      if (rxs_ff != 0) begin
         n_in           = num_t_ff;
         d_in           = rxs_ff;
         ctl_in.cand    = u_ok;
         ctl_in.check_t = !inf3_ff;
      end else begin
         n_in           = min_ok ? nmin : nmax;
         d_in           = rr_ff;
         ctl_in.cand    = (num_t_ff == 0) && (rr_ff != 0) && (min_ok || max_ok);
         ctl_in.check_t = 1'b0;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff   <= diff16(in_data.first_end_x, in_data.first_start_x);
         ry_ff   <= diff16(in_data.first_end_y, in_data.first_start_y);
         sx_ff   <= diff16(in_data.second_end_x, in_data.second_start_x);
         sy_ff   <= diff16(in_data.second_end_y, in_data.second_start_y);
         dx_ff   <= diff16(in_data.second_start_x, in_data.first_start_x);
         dy_ff   <= diff16(in_data.second_start_y, in_data.first_start_y);
         ex_ff   <= diff16(in_data.second_end_x, in_data.first_start_x);
         ey_ff   <= diff16(in_data.second_end_y, in_data.first_start_y);
         inf1_ff <= in_data.infinite_first;

         p_rxsy_ff <= rx_ff * sy_ff;
         p_rysx_ff <= ry_ff * sx_ff;
         p_dxsy_ff <= dx_ff * sy_ff;
         p_dysx_ff <= dy_ff * sx_ff;
         p_dxry_ff <= dx_ff * ry_ff;
         p_dyrx_ff <= dy_ff * rx_ff;
         p_rxrx_ff <= rx_ff * rx_ff;
         p_ryry_ff <= ry_ff * ry_ff;
         p_dxrx_ff <= dx_ff * rx_ff;
         p_dyry_ff <= dy_ff * ry_ff;
         p_exrx_ff <= ex_ff * rx_ff;
         p_eyry_ff <= ey_ff * ry_ff;
         inf2_ff   <= inf1_ff;

         rxs_ff   <= SUM_W'(p_rxsy_ff) - SUM_W'(p_rysx_ff);
         num_t_ff <= SUM_W'(p_dxsy_ff) - SUM_W'(p_dysx_ff);
         num_u_ff <= SUM_W'(p_dxry_ff) - SUM_W'(p_dyrx_ff);
         rr_ff    <= SUM_W'(p_rxrx_ff) + SUM_W'(p_ryry_ff);
         n0_ff    <= SUM_W'(p_dxrx_ff) + SUM_W'(p_dyry_ff);
         n1_ff    <= SUM_W'(p_exrx_ff) + SUM_W'(p_eyry_ff);
         inf3_ff  <= inf2_ff;

         n_ff   <= n_in;
         d_ff   <= d_in;
         ctl_ff <= ctl_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_n     = n_ff;
   assign out_d     = d_ff;
   assign out_ctl   = ctl_ff;

endmodule

@@ src/ssi_div.sv @@
module ssi_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [ssi_pkg::SUM_W-1:0]  in_n,
   input  logic signed [ssi_pkg::SUM_W-1:0]  in_d,
   input  ssi_pkg::cand_type                 in_ctl,
   output logic                              out_valid,
   output ssi_pkg::rsp_type                  out_rsp
);
   import ssi_pkg::*;

   // stage a: magnitudes and sign
   logic [MAG_W-1:0] un_ff, ud_ff;
   logic             nega_ff, va_ff;
   cand_type         ctla_ff;
   // stage b: rounding numerator and doubled divisor
   logic [NUM_W-1:0] numb_ff;
   logic [DEN_W-1:0] denb_ff;
   logic             negb_ff, vb_ff;
   cand_type         ctlb_ff;
   // one-bit restoring steps, index 0 filled by the overflow stage
   logic [REM_W-1:0] rem_ff [0:QUO_W];
   logic [DEN_W-1:0] den_ff [0:QUO_W];
   logic [QUO_W-1:0] q_ff   [0:QUO_W];
   logic             neg_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];
   logic             v_ff   [0:QUO_W];
   cand_type         ctl_ff [0:QUO_W];
   // output stage
   rsp_type          rsp_ff, rsp_in;
   logic             vo_ff;

   logic [QUO_W-2:0] mag;
   logic             sat, in_range;
   logic [T_W-1:0]   t_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         v_ff[0] <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         v_ff[0] <= vb_ff;
         vo_ff <= v_ff[QUO_W];
      end
   end

   // front stages: magnitude, numerator with half divisor, overflow test
   always_ff @(posedge clock) begin
      if (en) begin
         un_ff   <= in_n[SUM_W-1] ? MAG_W'(-in_n) : MAG_W'(in_n);
         ud_ff   <= in_d[SUM_W-1] ? MAG_W'(-in_d) : MAG_W'(in_d);
         nega_ff <= in_n[SUM_W-1] ^ in_d[SUM_W-1];
         ctla_ff <= in_ctl;

         numb_ff <= NUM_W'({un_ff, {FRAC_W{1'b0}}, 1'b0}) + NUM_W'(ud_ff);
         denb_ff <= {ud_ff, 1'b0};
         negb_ff <= nega_ff;
         ctlb_ff <= ctla_ff;

         rem_ff[0] <= REM_W'(numb_ff);
         den_ff[0] <= denb_ff;
         q_ff[0]   <= '0;
         neg_ff[0] <= negb_ff;
         ovf_ff[0] <= REM_W'(numb_ff) >= (REM_W'(denb_ff) << QUO_W);
         ctl_ff[0] <= ctlb_ff;
      end
   end

   // quotient bits, most significant first
   for (genvar j = 0; j < QUO_W; j++) begin : g_step
      logic [REM_W-1:0] shifted;
      logic             take;
      assign shifted = REM_W'(den_ff[j]) << (QUO_W - 1 - j);
      assign take    = rem_ff[j] >= shifted;

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j+1] <= 1'b0;
         end else if (en) begin
            v_ff[j+1] <= v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1] <= take ? (rem_ff[j] - shifted) : rem_ff[j];
            q_ff[j+1]   <= q_ff[j] | (QUO_W'(take) << (QUO_W - 1 - j));
            den_ff[j+1] <= den_ff[j];
            neg_ff[j+1] <= neg_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
            ctl_ff[j+1] <= ctl_ff[j];
         end
      end
   end

   // saturation, sign and final hit decision
   always_comb begin
      sat      = ovf_ff[QUO_W] || q_ff[QUO_W][QUO_W-1];
      mag      = q_ff[QUO_W][QUO_W-2:0];
      in_range = !sat && (!neg_ff[QUO_W] || (mag == '0)) && (mag <= T_ONE);
      if (sat) begin
         t_val = neg_ff[QUO_W] ? T_MIN : T_MAX;
      end else if (neg_ff[QUO_W]) begin
         t_val = -{1'b0, mag};
      end else begin
         t_val = {1'b0, mag};
      end
      rsp_in.hit       = ctl_ff[QUO_W].cand && (!ctl_ff[QUO_W].check_t || in_range);
      rsp_in.hit_param = rsp_in.hit ? t_val : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_rsp   = rsp_ff;

   // a miss always carries a zero parameter
   assert property (@(posedge clock) disable iff (reset)
      (vo_ff && !rsp_ff.hit) |-> (rsp_ff.hit_param == '0))
      else $error("miss carries a nonzero parameter");

endmodule

@@ src/ssi_out_fifo.sv @@
module ssi_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  ssi_pkg::rsp_type in_data,
   output logic             room,
   output logic             out_valid,
   input  logic             out_ready,
   output ssi_pkg::rsp_type out_data
);
   import ssi_pkg::*;

   rsp_type    ent_ff [0:1];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign room      = (cnt_ff != 2'd2);
   assign push      = room && in_valid;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_ready;
   assign out_data  = ent_ff[rd_ff];

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ff <= !wr_ff;
         end
         if (pop) begin
            rd_ff <= !rd_ff;
         end
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= in_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("result buffer overfilled");

   assert property (@(posedge clock) disable iff (reset)
      (wr_ff != rd_ff) == (cnt_ff == 2'd1))
      else $error("result buffer pointers disagree with count");

   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && !out_ready) |=> (cnt_ff == 2'd2))
      else $error("full result buffer lost a beat");

endmodule
